// ===== rtl/xdopc_pkg.sv =====
// Package for the X-drive odometry P controller.
// Types, constants and helper functions shared by xdopc_unit and the top level.
// No dependencies.
package xdopc_pkg;

  localparam int unsigned McandW  = 32;
  localparam int unsigned MplierW = 51;
  localparam int unsigned ResW    = 66;
  localparam int unsigned CntW    = 6;

  localparam logic [CntW-1:0] MulSteps = CntW'(33);
  localparam logic [CntW-1:0] DivSteps = CntW'(51);

  localparam logic [25:0] WheelK = 26'd37269603;
  localparam logic [29:0] DiagC  = 30'd759250125;
  localparam logic [31:0] TurnG  = 32'd3467971343;
  localparam logic signed [26:0] Heading180 = 27'sd11796480;

  localparam logic signed [31:0] RstTargetX     = 32'sd0;
  localparam logic signed [31:0] RstTargetY     = 32'sd0;
  localparam logic signed [25:0] RstTargetHead  = 26'sd5898240;
  localparam logic [15:0]        RstCountsRev   = 16'd200;
  localparam logic [30:0]        RstOutputLimit = 31'd242483;

  typedef enum logic {
    UOP_MUL,
    UOP_DIV
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    CFG_TARGET_X       = 3'd0,
    CFG_TARGET_Y       = 3'd1,
    CFG_TARGET_HEADING = 3'd2,
    CFG_COUNTS_PER_REV = 3'd3,
    CFG_OUTPUT_LIMIT   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUMS,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_ERRS,
    ST_MULG,
    ST_MULA,
    ST_MULB,
    ST_OUT
  } ctrl_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [52:0] hi;
    logic signed [52:0] lo;
    hi = 53'sd2147483647;
    lo = -53'sd2147483648;
    if (v > hi) begin
      sat32 = 32'h7fffffff;
    end else if (v < lo) begin
      sat32 = 32'h80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] clamp_lim(input logic signed [33:0] v,
                                                   input logic [30:0] lim);
    logic signed [33:0] pos;
    logic signed [33:0] neg;
    pos = $signed({3'b000, lim});
    neg = -pos;
    if (v > pos) begin
      clamp_lim = pos[31:0];
    end else if (v < neg) begin
      clamp_lim = neg[31:0];
    end else begin
      clamp_lim = v[31:0];
    end
  endfunction

  function automatic logic [32:0] abs33(input logic signed [33:0] v);
    logic signed [33:0] n;
    n = -v;
    abs33 = v[33] ? n[32:0] : v[32:0];
  endfunction

  // floor((p + 2^29) / 2^30) with p = +/- mag
  function automatic logic signed [35:0] rnd30(input logic neg, input logic [64:0] mag);
    logic signed [65:0] p;
    logic signed [65:0] w;
    p = $signed({1'b0, mag});
    if (neg) begin
      p = -p;
    end
    w = p + 66'sd536870912;
    rnd30 = w[65:30];
  endfunction

endpackage

// ===== rtl/xdopc_unit.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// One bit per cycle; operands are unsigned magnitudes. Uses xdopc_pkg.
module xdopc_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  xdopc_pkg::unit_ctrl_t          ctrl_i,
  input  logic [xdopc_pkg::McandW-1:0]   mcand_i,
  input  logic [xdopc_pkg::MplierW-1:0]  mplier_i,
  output xdopc_pkg::unit_stat_t          stat_o,
  output logic [xdopc_pkg::ResW-1:0]     result_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  xdopc_pkg::unit_op_e           op_q, op_d;
  logic [xdopc_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [67:0]                   w_q, w_d;
  logic [xdopc_pkg::McandW-1:0]  mcand_q, mcand_d;

  logic [34:0] mul_sum;
  logic [16:0] div_shift;
  logic [17:0] div_diff;
  logic        div_ge;
  logic [16:0] div_rem;

  always_comb begin
    mul_sum   = w_q[67:33] + (w_q[0] ? {3'b000, mcand_q} : 35'd0);
    div_shift = {w_q[66:51], w_q[50]};
    div_diff  = {1'b0, div_shift} - {2'b00, mcand_q[15:0]};
    div_ge    = ~div_diff[17];
    div_rem   = div_ge ? div_diff[16:0] : div_shift;

    busy_d  = busy_q;
    done_d  = 1'b0;
    op_d    = op_q;
    cnt_d   = cnt_q;
    w_d     = w_q;
    mcand_d = mcand_q;

    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      op_d    = ctrl_i.op;
      mcand_d = mcand_i;
      if (ctrl_i.op == xdopc_pkg::UOP_MUL) begin
        cnt_d = xdopc_pkg::MulSteps;
        w_d   = {35'd0, mplier_i[32:0]};
      end else begin
        cnt_d = xdopc_pkg::DivSteps;
        w_d   = {17'd0, mplier_i};
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (op_q == xdopc_pkg::UOP_MUL) begin
        w_d = {1'b0, mul_sum, w_q[32:1]};
      end else begin
        w_d = {div_rem, w_q[49:0], div_ge};
      end
      if (cnt_q == xdopc_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= xdopc_pkg::UOP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    mcand_q <= mcand_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = w_q[65:0];

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("unit started while busy");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("done without a finished run");

  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("busy with empty step count");

endmodule

// ===== rtl/xdrive_odometry_p_controller_unit.sv =====
// X-drive odometry with proportional position and heading control.
// Takes one input word at a time: s_axis_tready is high only in idle, and the
// word is worked through the shared bit-serial unit, two multiply-divide pairs
// plus three multiplies per word; the result waits in ST_OUT for a free output.
// Output register holds a result while the next word is taken.
// Reset clears wheel counts and position, and loads register defaults.
module xdrive_odometry_p_controller_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // wheel_count_a, wheel_count_b, wheel_count_c, wheel_count_d, measured_heading
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // speed_a, speed_b, speed_c, speed_d
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  xdopc_pkg::ctrl_state_e state_q, state_d;
  logic issued_q, issued_d;

  logic signed [31:0] tgt_x_q, tgt_x_d;
  logic signed [31:0] tgt_y_q, tgt_y_d;
  logic signed [25:0] tgt_h_q, tgt_h_d;
  logic [15:0]        cpr_q, cpr_d;
  logic [30:0]        lim_q, lim_d;

  logic [31:0]        last_q [4];
  logic [31:0]        last_d [4];
  logic signed [31:0] pos_x_q, pos_x_d;
  logic signed [31:0] pos_y_q, pos_y_d;

  logic signed [31:0] dlt_q [4];
  logic signed [31:0] dlt_d [4];
  logic signed [25:0] meas_q, meas_d;
  logic signed [33:0] sx_q, sx_d;
  logic signed [33:0] sy_q, sy_d;
  logic signed [31:0] ux_q, ux_d;
  logic signed [31:0] uy_q, uy_d;
  logic signed [31:0] ut_q, ut_d;
  logic signed [35:0] g_q, g_d;
  logic signed [35:0] a_q, a_d;
  logic signed [35:0] b_q, b_d;
  logic signed [35:0] c_q, c_d;
  logic signed [35:0] e_q, e_d;

  logic               out_vld_q, out_vld_d;
  logic signed [31:0] spd_q [4];
  logic signed [31:0] spd_d [4];

  xdopc_pkg::unit_ctrl_t           u_ctrl;
  xdopc_pkg::unit_stat_t           u_stat;
  logic [xdopc_pkg::McandW-1:0]    u_mcand;
  logic [xdopc_pkg::MplierW-1:0]   u_mplier;
  logic [xdopc_pkg::ResW-1:0]      u_res;

  logic [15:0]        cpr_eff;
  logic signed [32:0] s0;
  logic signed [32:0] s1;
  logic signed [52:0] q_sgn;
  logic signed [33:0] err_x;
  logic signed [33:0] err_y;
  logic signed [26:0] head_tm;
  logic signed [26:0] head_mt;
  logic signed [26:0] head_e;

  xdopc_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (u_ctrl),
    .mcand_i (u_mcand),
    .mplier_i(u_mplier),
    .stat_o  (u_stat),
    .result_o(u_res)
  );

  always_comb begin
    cpr_eff = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
    s0      = $signed({ux_q[31], ux_q}) + $signed({uy_q[31], uy_q});
    s1      = $signed({ux_q[31], ux_q}) - $signed({uy_q[31], uy_q});
    err_x   = $signed({{2{tgt_x_q[31]}}, tgt_x_q}) - $signed({{2{pos_x_q[31]}}, pos_x_q});
    err_y   = $signed({{2{tgt_y_q[31]}}, tgt_y_q}) - $signed({{2{pos_y_q[31]}}, pos_y_q});
    head_tm = $signed({tgt_h_q[25], tgt_h_q}) - $signed({meas_q[25], meas_q});
    head_mt = $signed({meas_q[25], meas_q}) - $signed({tgt_h_q[25], tgt_h_q});
    head_e  = (head_tm == xdopc_pkg::Heading180) ? xdopc_pkg::Heading180 : head_mt;
    q_sgn   = $signed({2'b00, u_res[50:0]});

    state_d   = state_q;
    issued_d  = issued_q;
    tgt_x_d   = tgt_x_q;
    tgt_y_d   = tgt_y_q;
    tgt_h_d   = tgt_h_q;
    cpr_d     = cpr_q;
    lim_d     = lim_q;
    last_d    = last_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    dlt_d     = dlt_q;
    meas_d    = meas_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    ux_d      = ux_q;
    uy_d      = uy_q;
    ut_d      = ut_q;
    g_d       = g_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    e_d       = e_q;
    spd_d     = spd_q;
    out_vld_d = out_vld_q;

    u_ctrl.start = 1'b0;
    u_ctrl.op    = xdopc_pkg::UOP_MUL;
    u_mcand      = '0;
    u_mplier     = '0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (xdopc_pkg::cfg_idx_e'(cfg_addr_i))
        xdopc_pkg::CFG_TARGET_X:       tgt_x_d = cfg_wdata_i;
        xdopc_pkg::CFG_TARGET_Y:       tgt_y_d = cfg_wdata_i;
        xdopc_pkg::CFG_TARGET_HEADING: tgt_h_d = cfg_wdata_i[25:0];
        xdopc_pkg::CFG_COUNTS_PER_REV: cpr_d   = cfg_wdata_i[15:0];
        xdopc_pkg::CFG_OUTPUT_LIMIT:   lim_d   = cfg_wdata_i[30:0];
        default: ;
      endcase
    end

    case (state_q)
      xdopc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 4; i++) begin
            last_d[i] = s_axis_tdata[32*i +: 32];
            dlt_d[i]  = s_axis_tdata[32*i +: 32] - last_q[i];
          end
          meas_d  = s_axis_tdata[153:128];
          state_d = xdopc_pkg::ST_SUMS;
        end
      end
      xdopc_pkg::ST_SUMS: begin
        sx_d = $signed({{2{dlt_q[0][31]}}, dlt_q[0]}) + $signed({{2{dlt_q[1][31]}}, dlt_q[1]})
             - $signed({{2{dlt_q[2][31]}}, dlt_q[2]}) - $signed({{2{dlt_q[3][31]}}, dlt_q[3]});
        sy_d = $signed({{2{dlt_q[0][31]}}, dlt_q[0]}) - $signed({{2{dlt_q[1][31]}}, dlt_q[1]})
             - $signed({{2{dlt_q[2][31]}}, dlt_q[2]}) + $signed({{2{dlt_q[3][31]}}, dlt_q[3]});
        state_d = xdopc_pkg::ST_MULX;
      end
      xdopc_pkg::ST_MULX, xdopc_pkg::ST_MULY: begin
        u_ctrl.op = xdopc_pkg::UOP_MUL;
        u_mcand   = {6'd0, xdopc_pkg::WheelK};
        u_mplier  = {18'd0, xdopc_pkg::abs33((state_q == xdopc_pkg::ST_MULX) ? sx_q : sy_q)};
        if (!issued_q) begin
          u_ctrl.start = 1'b1;
          issued_d     = 1'b1;
        end else if (u_stat.done) begin
          issued_d = 1'b0;
          state_d  = (state_q == xdopc_pkg::ST_MULX) ? xdopc_pkg::ST_DIVX : xdopc_pkg::ST_DIVY;
        end
      end
      xdopc_pkg::ST_DIVX: begin
        u_ctrl.op = xdopc_pkg::UOP_DIV;
        u_mcand   = {16'd0, cpr_eff};
        u_mplier  = u_res[58:8];
        if (!issued_q) begin
          u_ctrl.start = 1'b1;
          issued_d     = 1'b1;
        end else if (u_stat.done) begin
          issued_d = 1'b0;
          pos_x_d  = xdopc_pkg::sat32($signed({{21{pos_x_q[31]}}, pos_x_q})
                                      + (sx_q[33] ? -q_sgn : q_sgn));
          state_d  = xdopc_pkg::ST_MULY;
        end
      end
      xdopc_pkg::ST_DIVY: begin
        u_ctrl.op = xdopc_pkg::UOP_DIV;
        u_mcand   = {16'd0, cpr_eff};
        u_mplier  = u_res[58:8];
        if (!issued_q) begin
          u_ctrl.start = 1'b1;
          issued_d     = 1'b1;
        end else if (u_stat.done) begin
          issued_d = 1'b0;
          pos_y_d  = xdopc_pkg::sat32($signed({{21{pos_y_q[31]}}, pos_y_q})
                                      + (sy_q[33] ? -q_sgn : q_sgn));
          state_d  = xdopc_pkg::ST_ERRS;
        end
      end
      xdopc_pkg::ST_ERRS: begin
        ux_d    = xdopc_pkg::clamp_lim(err_x, lim_q);
        uy_d    = xdopc_pkg::clamp_lim(err_y, lim_q);
        ut_d    = xdopc_pkg::clamp_lim({{7{head_e[26]}}, head_e}, lim_q);
        state_d = xdopc_pkg::ST_MULG;
      end
      xdopc_pkg::ST_MULG: begin
        u_ctrl.op = xdopc_pkg::UOP_MUL;
        u_mcand   = xdopc_pkg::TurnG;
        u_mplier  = {18'd0, xdopc_pkg::abs33({{2{ut_q[31]}}, ut_q})};
        if (!issued_q) begin
          u_ctrl.start = 1'b1;
          issued_d     = 1'b1;
        end else if (u_stat.done) begin
          issued_d = 1'b0;
          g_d      = xdopc_pkg::rnd30(ut_q[31], u_res[64:0]);
          state_d  = xdopc_pkg::ST_MULA;
        end
      end
      xdopc_pkg::ST_MULA: begin
        u_ctrl.op = xdopc_pkg::UOP_MUL;
        u_mcand   = {2'b00, xdopc_pkg::DiagC};
        u_mplier  = {18'd0, xdopc_pkg::abs33({s0[32], s0})};
        if (!issued_q) begin
          u_ctrl.start = 1'b1;
          issued_d     = 1'b1;
        end else if (u_stat.done) begin
          issued_d = 1'b0;
          a_d      = xdopc_pkg::rnd30(s0[32], u_res[64:0]);
          c_d      = xdopc_pkg::rnd30(~s0[32], u_res[64:0]);
          state_d  = xdopc_pkg::ST_MULB;
        end
      end
      xdopc_pkg::ST_MULB: begin
        u_ctrl.op = xdopc_pkg::UOP_MUL;
        u_mcand   = {2'b00, xdopc_pkg::DiagC};
        u_mplier  = {18'd0, xdopc_pkg::abs33({s1[32], s1})};
        if (!issued_q) begin
          u_ctrl.start = 1'b1;
          issued_d     = 1'b1;
        end else if (u_stat.done) begin
          issued_d = 1'b0;
          b_d      = xdopc_pkg::rnd30(s1[32], u_res[64:0]);
          e_d      = xdopc_pkg::rnd30(~s1[32], u_res[64:0]);
          state_d  = xdopc_pkg::ST_OUT;
        end
      end
      xdopc_pkg::ST_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          spd_d[0]  = xdopc_pkg::sat32({{17{a_q[35]}}, a_q} + {{17{g_q[35]}}, g_q});
          spd_d[1]  = xdopc_pkg::sat32({{17{b_q[35]}}, b_q} + {{17{g_q[35]}}, g_q});
          spd_d[2]  = xdopc_pkg::sat32({{17{c_q[35]}}, c_q} + {{17{g_q[35]}}, g_q});
          spd_d[3]  = xdopc_pkg::sat32({{17{e_q[35]}}, e_q} + {{17{g_q[35]}}, g_q});
          out_vld_d = 1'b1;
          state_d   = xdopc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d  = xdopc_pkg::ST_IDLE;
        issued_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= xdopc_pkg::ST_IDLE;
      issued_q  <= 1'b0;
      out_vld_q <= 1'b0;
      tgt_x_q   <= xdopc_pkg::RstTargetX;
      tgt_y_q   <= xdopc_pkg::RstTargetY;
      tgt_h_q   <= xdopc_pkg::RstTargetHead;
      cpr_q     <= xdopc_pkg::RstCountsRev;
      lim_q     <= xdopc_pkg::RstOutputLimit;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      for (int i = 0; i < 4; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      issued_q  <= issued_d;
      out_vld_q <= out_vld_d;
      tgt_x_q   <= tgt_x_d;
      tgt_y_q   <= tgt_y_d;
      tgt_h_q   <= tgt_h_d;
      cpr_q     <= cpr_d;
      lim_q     <= lim_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dlt_q  <= dlt_d;
    meas_q <= meas_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    ux_q   <= ux_d;
    uy_q   <= uy_d;
    ut_q   <= ut_d;
    g_q    <= g_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    e_q    <= e_d;
    spd_q  <= spd_d;
  end

  assign s_axis_tready = (state_q == xdopc_pkg::ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {spd_q[3], spd_q[2], spd_q[1], spd_q[0]};

endmodule
